@@ sv/mpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants of the manchester pair decoder: the pair codes
// and the compacted entry that the classifier hands to the bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

  localparam int unsigned PairsPerByte = 4;
  localparam int unsigned ByteBits     = 8;
  localparam int unsigned TotalFieldW  = 16;

  // half-bit pair codes, first sample in the upper bit
  localparam logic [1:0] PairOne  = 2'b01;
  localparam logic [1:0] PairZero = 2'b10;

  // decoded bits of one raw byte, packed MSB first, unused low bits zero
  typedef struct packed {
    logic [PairsPerByte-1:0] bits;
    logic [2:0]              cnt;
    logic                    last;
  } pair_entry_t;

endpackage

`default_nettype wire

@@ sv/manchester_pair_decoder.sv @@
// ----------------------------------------------------------------------------
// manchester_pair_decoder
// Decodes raw half-bit pair bytes (01 is 1, 10 is 0, others dropped) and
// packs the bits MSB first into bytes, closing each frame with a bit total.
// ----------------------------------------------------------------------------
// One raw byte is taken per cycle while the queue is not full. The classifier
// compacts the valid pairs in the accepting cycle and writes them to a
// two-entry queue; the packer takes one entry per cycle unless a result waits
// on the output stall, so the sustained rate is one item per cycle. The single
// exception is an item that both completes a byte and ends the frame: it gives
// two results through the one output register and holds the packer until the
// second is loaded. Results pass the queue and the output register. total_bits
// saturates at 65535, and the internal count at 2^COUNT_WIDTH - 1.
`default_nettype none

module manchester_pair_decoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  raw_byte_i,
  input  logic [2:0]  pairs_in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  decoded_byte_o,
  output logic [3:0]  bits_in_byte_o,
  output logic [15:0] total_bits_o,
  output logic        frame_end_o
);
  import mpd_pkg::*;

  logic        push;
  logic        pop;
  logic        queue_full;
  logic        head_valid;
  pair_entry_t entry;
  pair_entry_t head;

  mpd_front u_front (
    .in_valid_i      (in_valid_i),
    .queue_full_i    (queue_full),
    .raw_byte_i      (raw_byte_i),
    .pairs_in_byte_i (pairs_in_byte_i),
    .last_byte_i     (last_byte_i),
    .in_stall_o      (in_stall_o),
    .push_o          (push),
    .entry_o         (entry)
  );

  mpd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .pop_i        (pop),
    .full_o       (queue_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  mpd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .decoded_byte_o (decoded_byte_o),
    .bits_in_byte_o (bits_in_byte_o),
    .total_bits_o   (total_bits_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

`default_nettype wire

@@ sv/mpd_front.sv @@
// ----------------------------------------------------------------------------
// mpd_front
// Classifier: decodes the leading pairs of a raw byte, drops the invalid
// ones and compacts the surviving bits MSB first for the packer queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_front (
  input  logic                in_valid_i,
  input  logic                queue_full_i,
  input  logic [7:0]          raw_byte_i,
  input  logic [2:0]          pairs_in_byte_i,
  input  logic                last_byte_i,
  output logic                in_stall_o,
  output logic                push_o,
  output mpd_pkg::pair_entry_t entry_o
);
  import mpd_pkg::*;

  logic [2:0] npairs;
  logic [1:0] pair;
  logic [PairsPerByte-1:0] bits;
  logic [2:0] cnt;

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    // anything above four pairs counts as four
    npairs = (pairs_in_byte_i > 3'(PairsPerByte)) ? 3'(PairsPerByte) : pairs_in_byte_i;
    bits   = '0;
    cnt    = '0;
    pair   = '0;
    for (int p = 0; p < PairsPerByte; p++) begin
      pair = raw_byte_i[7-2*p -: 2];
      if ((3'(p) < npairs) && (pair == PairOne || pair == PairZero)) begin
        bits[2'(3'd3 - cnt)] = (pair == PairOne);
        cnt = cnt + 3'd1;
      end
    end
  end

  always_comb begin
    entry_o.bits = bits;
    entry_o.cnt  = cnt;
    entry_o.last = last_byte_i;
  end

endmodule

`default_nettype wire

@@ sv/mpd_queue.sv @@
// ----------------------------------------------------------------------------
// mpd_queue
// Two-entry queue between the classifier and the packer; a stall on one
// side holds up the other only once the queue runs full or empty.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mpd_pkg::pair_entry_t entry_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 head_valid_o,
  output mpd_pkg::pair_entry_t head_o
);
  import mpd_pkg::*;

  pair_entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/mpd_back.sv @@
// ----------------------------------------------------------------------------
// mpd_back
// Packer: appends queued bits to the pack register, emits full bytes and
// the frame closing result through an output register, keeps the bit total.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_back #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  mpd_pkg::pair_entry_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           decoded_byte_o,
  output logic [3:0]           bits_in_byte_o,
  output logic [15:0]          total_bits_o,
  output logic                 frame_end_o
);
  import mpd_pkg::*;

  localparam int unsigned ExtW = (COUNT_WIDTH > TotalFieldW) ? COUNT_WIDTH : TotalFieldW;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(logic [COUNT_WIDTH-1:0] a,
                                                     logic [3:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + (COUNT_WIDTH+1)'(b);
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [15:0] total_field(logic [COUNT_WIDTH-1:0] t);
    logic [ExtW-1:0] e;
    e = ExtW'(t);
    return (e > ExtW'(16'hFFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  logic [7:0]             pack_q, pack_d;
  logic [2:0]             fill_q, fill_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic                   phase_q, phase_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             byte_q, byte_d;
  logic [3:0]             nbits_q, nbits_d;
  logic [15:0]            tfield_q, tfield_d;
  logic                   end_q, end_d;

  logic                   load_en;
  logic                   emit;
  logic [3:0]             sum;
  logic [11:0]            wide;
  logic                   full;
  logic [COUNT_WIDTH-1:0] total_full;
  logic [COUNT_WIDTH-1:0] total_after;

  assign load_en = !out_valid_q || !out_stall_i;
  assign sum     = {1'b0, fill_q} + {1'b0, head_i.cnt};
  assign wide    = {pack_q, 4'b0000} | ({head_i.bits, 8'h00} >> fill_q);
  assign full    = (sum >= 4'd8);
  // total as it stands when the eighth bit lands
  assign total_full  = sat_add(total_q, 4'd8 - {1'b0, fill_q});
  assign total_after = sat_add(total_q, {1'b0, head_i.cnt});

  always_comb begin
    pop_o    = 1'b0;
    emit     = 1'b0;
    byte_d   = byte_q;
    nbits_d  = nbits_q;
    tfield_d = tfield_q;
    end_d    = end_q;
    pack_d   = pack_q;
    fill_d   = fill_q;
    total_d  = total_q;
    phase_d  = phase_q;
    if (head_valid_i) begin
      if (phase_q) begin
        // closing result after a full byte of the same item
        if (load_en) begin
          emit     = 1'b1;
          byte_d   = pack_q;
          nbits_d  = {1'b0, fill_q};
          tfield_d = total_field(total_q);
          end_d    = 1'b1;
          pack_d   = '0;
          fill_d   = '0;
          total_d  = '0;
          phase_d  = 1'b0;
          pop_o    = 1'b1;
        end
      end else if (full) begin
        if (load_en) begin
          emit     = 1'b1;
          byte_d   = wide[11:4];
          nbits_d  = 4'd8;
          tfield_d = total_field(total_full);
          end_d    = 1'b0;
          pack_d   = {wide[3:0], 4'b0000};
          fill_d   = 3'(sum - 4'd8);
          total_d  = total_after;
          if (head_i.last) begin
            phase_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end
      end else if (head_i.last) begin
        if (load_en) begin
          emit     = 1'b1;
          byte_d   = wide[11:4];
          nbits_d  = sum;
          tfield_d = total_field(total_after);
          end_d    = 1'b1;
          pack_d   = '0;
          fill_d   = '0;
          total_d  = '0;
          pop_o    = 1'b1;
        end
      end else begin
        pack_d  = wide[11:4];
        fill_d  = sum[2:0];
        total_d = total_after;
        pop_o   = 1'b1;
      end
    end
    out_valid_d = emit ? 1'b1 : (load_en ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q   <= byte_d;
      nbits_q  <= nbits_d;
      tfield_q <= tfield_d;
      end_q    <= end_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q      <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pack_q      <= pack_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign decoded_byte_o = byte_q;
  assign bits_in_byte_o = nbits_q;
  assign total_bits_o   = tfield_q;
  assign frame_end_o    = end_q;

endmodule

`default_nettype wire

@@ sim/tb_manchester_pair_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_manchester_pair_decoder
// Drives raw half-bit pair bytes into the decoder over the valid/stall
// handshake. A built-in decoder model predicts the packed bytes and frame
// closes, typed directed rows aside, and the results are checked in order.
// The run covers a directed table, a long clean frame, and random frames
// under four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_manchester_pair_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import mpd_pkg::*;

  localparam int unsigned CountW = 16;

  // pairs that decode to nothing
  localparam logic [1:0] PairLow  = 2'b00;
  localparam logic [1:0] PairHigh = 2'b11;

  typedef struct packed {
    logic [7:0]  data;
    logic [3:0]  nbits;
    logic [15:0] total;
    logic        frame_end;
  } decode_result_t;

  typedef struct packed {
    logic [7:0]     raw;
    logic [2:0]     pairs;
    logic           last;
    logic           typed;
    decode_result_t fixed;
  } raw_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  raw_byte_i      = 8'h00;
  logic [2:0]  pairs_in_byte_i = 3'd0;
  logic        last_byte_i     = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [7:0]  decoded_byte_o;
  logic [3:0]  bits_in_byte_o;
  logic [15:0] total_bits_o;
  logic        frame_end_o;

  manchester_pair_decoder #(
    .COUNT_WIDTH (CountW)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .raw_byte_i      (raw_byte_i),
    .pairs_in_byte_i (pairs_in_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .decoded_byte_o  (decoded_byte_o),
    .bits_in_byte_o  (bits_in_byte_o),
    .total_bits_o    (total_bits_o),
    .frame_end_o     (frame_end_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned n_faults      = 0;
  int unsigned n_results     = 0;

  decode_result_t pending_decodes[$];
  decode_result_t fresh_results[$];

  // decoder model state
  logic [7:0]        pack_reg  = 8'h00;
  logic [3:0]        pack_fill = 4'd0;
  logic [CountW-1:0] bit_total = '0;

  // rows typed in are read straight off the decoding rules
  raw_row_t directed_rows [19] = '{
    '{8'h00, 3'd4, 1'b1, 1'b1, '{8'h00, 4'd0, 16'd0, 1'b1}},
    '{8'hFF, 3'd4, 1'b1, 1'b1, '{8'h00, 4'd0, 16'd0, 1'b1}},
    '{8'h55, 3'd4, 1'b0, 1'b0, '0},
    '{8'h55, 3'd4, 1'b0, 1'b1, '{8'hFF, 4'd8, 16'd8, 1'b0}},
    '{8'hAA, 3'd4, 1'b0, 1'b0, '0},
    '{8'hAA, 3'd4, 1'b1, 1'b0, '0},
    '{8'h55, 3'd0, 1'b1, 1'b1, '{8'h00, 4'd0, 16'd0, 1'b1}},
    '{8'h55, 3'd7, 1'b1, 1'b1, '{8'hF0, 4'd4, 16'd4, 1'b1}},
    '{8'h55, 3'd5, 1'b0, 1'b0, '0},
    '{8'h96, 3'd6, 1'b0, 1'b0, '0},
    '{8'h69, 3'd3, 1'b1, 1'b0, '0},
    '{8'h1B, 3'd4, 1'b0, 1'b0, '0},
    '{8'hE4, 3'd2, 1'b0, 1'b0, '0},
    '{8'h59, 3'd1, 1'b1, 1'b0, '0},
    '{8'h5A, 3'd4, 1'b0, 1'b0, '0},
    '{8'hA5, 3'd4, 1'b0, 1'b0, '0},
    '{8'h66, 3'd3, 1'b0, 1'b0, '0},
    '{8'h99, 3'd4, 1'b1, 1'b0, '0},
    '{8'h3C, 3'd4, 1'b1, 1'b1, '{8'h00, 4'd0, 16'd0, 1'b1}}
  };

  function automatic logic [15:0] clamped_total();
    return (bit_total > 'hFFFF) ? 16'hFFFF : 16'(bit_total);
  endfunction

  // decodes one raw byte into fresh_results and advances the model state
  function automatic void decode_raw_byte(input logic [7:0] raw, input logic [2:0] pairs,
                                          input logic last);
    int unsigned n_pairs;
    int unsigned p;
    logic [1:0]  code;
    fresh_results.delete();
    n_pairs = (pairs > PairsPerByte) ? PairsPerByte : pairs;
    for (p = 0; p < n_pairs; p++) begin
      code = raw[7 - 2*p -: 2];
      if (code == PairOne || code == PairZero) begin
        pack_reg[7 - pack_fill] = (code == PairOne);
        pack_fill++;
        if (bit_total != '1) bit_total++;
        if (pack_fill == ByteBits) begin
          fresh_results.push_back(decode_result_t'{pack_reg, 4'd8, clamped_total(), 1'b0});
          pack_reg  = 8'h00;
          pack_fill = 4'd0;
        end
      end
    end
    if (last) begin
      fresh_results.push_back(decode_result_t'{pack_reg, pack_fill, clamped_total(), 1'b1});
      pack_reg  = 8'h00;
      pack_fill = 4'd0;
      bit_total = '0;
    end
  endfunction

  // returns at the edge where the transaction is taken
  task automatic send_raw(input logic [7:0] raw, input logic [2:0] pairs, input logic last,
                          input logic typed, input decode_result_t fixed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    raw_byte_i      <= raw;
    pairs_in_byte_i <= pairs;
    last_byte_i     <= last;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    decode_raw_byte(raw, pairs, last);
    if (typed) pending_decodes.push_back(fixed);
    else foreach (fresh_results[k]) pending_decodes.push_back(fresh_results[k]);
  endtask

  task automatic send_frame(input int unsigned n_items, input int unsigned noise_pct);
    logic [7:0]  raw;
    logic [2:0]  pairs;
    logic [1:0]  code;
    int unsigned i;
    int unsigned p;
    for (i = 0; i < n_items; i++) begin
      for (p = 0; p < PairsPerByte; p++) begin
        if ($urandom_range(99) < noise_pct) code = $urandom_range(1) ? PairHigh : PairLow;
        else code = $urandom_range(1) ? PairOne : PairZero;
        raw[7 - 2*p -: 2] = code;
      end
      pairs = 3'(PairsPerByte);
      if (i == n_items - 1) pairs = 3'($urandom_range(PairsPerByte));
      else if ($urandom_range(99) < noise_pct) pairs = 3'($urandom_range(7));
      send_raw(raw, pairs, i == n_items - 1, 1'b0, '0);
    end
  endtask

  // mostly clean frames, with some wholly random transactions mixed in
  task automatic random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(1, 12);
        send_frame(len, 5);
      end else begin
        len = 1;
        send_raw(8'($urandom), 3'($urandom), 1'($urandom), 1'b0, '0);
      end
      sent += len;
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin : check_results
    decode_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_decodes.size() == 0) begin
        n_faults++;
        if (n_faults <= 10)
          $display("result %0d: nothing expected, got byte %h bits %0d total %0d end %b",
                   n_results, decoded_byte_o, bits_in_byte_o, total_bits_o, frame_end_o);
      end else begin
        want = pending_decodes.pop_front();
        if (decoded_byte_o !== want.data || bits_in_byte_o !== want.nbits ||
            total_bits_o !== want.total || frame_end_o !== want.frame_end) begin
          n_faults++;
          if (n_faults <= 10)
            $display("result %0d: expected byte %h bits %0d total %0d end %b, got byte %h bits %0d total %0d end %b",
                     n_results, want.data, want.nbits, want.total, want.frame_end,
                     decoded_byte_o, bits_in_byte_o, total_bits_o, frame_end_o);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      send_raw(directed_rows[r].raw, directed_rows[r].pairs, directed_rows[r].last,
               directed_rows[r].typed, directed_rows[r].fixed);
    settle();

    // one long clean frame, so the bit total runs well past a byte
    send_frame(64, 0);
    settle();

    random_phase(105);
    settle();

    send_idle_pct = 77;
    random_phase(105);
    settle();

    send_idle_pct = 0;
    stall_pct     = 77;
    random_phase(105);
    settle();

    send_idle_pct = 33;
    stall_pct     = 33;
    random_phase(105);
    settle();

    if (n_faults == 0 && pending_decodes.size() == 0) begin
      $display("manchester_pair_decoder: match");
    end else begin
      $display("manchester_pair_decoder: mismatch");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("manchester_pair_decoder: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
sv/mpd_pkg.sv
sv/mpd_front.sv
sv/mpd_queue.sv
sv/mpd_back.sv
sv/manchester_pair_decoder.sv
sim/tb_manchester_pair_decoder.sv
